@@ design/ntc_pkg.sv @@
// Shared types, constants and helper functions for the NTC thermistor converter.
// Used by the converter top level and its port checker; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ntc_pkg;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_UNCAL  = 3'd1,
		ST_RANGE  = 3'd2,
		ST_RES    = 3'd3,
		ST_KELVIN = 3'd4
	} status_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_SUPPLY   = 3'd0,
		REG_FIXED_R  = 3'd1,
		REG_NOMINAL  = 3'd2,
		REG_REF_MK   = 3'd3,
		REG_BETA     = 3'd4,
		REG_CAL_UV   = 3'd5,
		REG_CAL_OHMS = 3'd6
	} reg_idx_t;

	localparam int V_W    = 23;
	localparam int R_W    = 24;
	localparam int T0_W   = 20;
	localparam int B_W    = 17;
	localparam int TEMP_W = 22;
	localparam int CFG_W  = 24;
	localparam int IDX_W  = 3;

	// Fraction bits of log2 produced by the squaring chain (8 to 32).
	localparam int LOG_STEPS = 16;

	// Division chain lengths: one quotient bit per stage plus an overflow check.
	localparam int OHMS_W = 24;
	localparam int LOGQ_W = 33;
	localparam int DIV_N  = LOGQ_W;
	localparam int TD_N   = TEMP_W + 1;

	localparam logic [31:0]     LN2_Q32   = 32'd2977044472;
	localparam logic [21:0]     KOFS_MK   = 22'd273150;
	localparam logic [21:0]     TK_MAX    = 22'd2273150;
	localparam logic [R_W-1:0]  OHMS_MAX  = '1;
	localparam logic [9:0]      MILLI     = 10'd1000;

	localparam logic [V_W-1:0]  RST_SUPPLY   = 23'd3300000;
	localparam logic [R_W-1:0]  RST_FIXED_R  = 24'd10000;
	localparam logic [R_W-1:0]  RST_NOMINAL  = 24'd10000;
	localparam logic [T0_W-1:0] RST_REF_MK   = 20'd298150;
	localparam logic [B_W-1:0]  RST_BETA     = 17'd4050;
	localparam logic [V_W-1:0]  RST_CAL_UV   = 23'd643000;
	localparam logic [R_W-1:0]  RST_CAL_OHMS = 24'd9600;

	// Item state while the resistance and the log mantissa are divided out.
	typedef struct packed {
		status_t           st;
		logic [V_W-1:0]    v;
		logic              sat_o;
		logic [OHMS_W-1:0] q_o;
		logic [95:0]       r_o;
		logic [70:0]       d;
		logic [96:0]       r_l;
		logic [95:0]       dd;
		logic [LOGQ_W-1:0] q_l;
		logic signed [7:0] e;
	} div_t;

	// Item state in the log2 squaring chain.
	typedef struct packed {
		status_t           st;
		logic [V_W-1:0]    v;
		logic [R_W-1:0]    ohms;
		logic [31:0]       m;
		logic [31:0]       frac;
		logic signed [7:0] e;
	} sq_t;

	// Item state in the Kelvin division chain.
	typedef struct packed {
		status_t           st;
		logic [V_W-1:0]    v;
		logic [R_W-1:0]    ohms;
		logic              kbad;
		logic              sat;
		logic [TEMP_W-1:0] q;
		logic [83:0]       r;
		logic [59:0]       den;
	} td_t;

	// Leading zero count of a 96-bit word; 96 for zero.
	function automatic logic [6:0] lzc96(input logic [95:0] x);
		logic [6:0] cnt;
		cnt = 7'd96;
		for (int i = 0; i < 96; i++) begin
			if (x[i]) begin
				cnt = 7'(95 - i);
			end
		end
		return cnt;
	endfunction

endpackage

`default_nettype wire

@@ design/ntc_thermistor_to_celsius_unit.sv @@
// Top level of the NTC thermistor to Celsius converter: register file and full pipeline.
// Depends on ntc_pkg for types, constants and the leading zero counter.
`timescale 1ns / 1ps
`default_nettype none

// One divider sample in microvolts enters per cycle and one result leaves per cycle
// while the output is not stalled. The pipeline is built mostly from restoring divisions,
// which produce one quotient bit per pipeline stage: a chain for the resistance and log
// mantissa, LOG_STEPS squaring stages for log2, and 23 stages for the Kelvin quotient.
// A stalled output holds the whole pipeline. The user must see that registers are written
// only while no sample is in flight; the block itself does not enforce this.
module ntc_thermistor_to_celsius_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [ntc_pkg::V_W-1:0]        sample_microvolts,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [2:0]                          status,
	output logic signed [ntc_pkg::TEMP_W-1:0]   temp_millicelsius,
	output logic [ntc_pkg::R_W-1:0]             thermistor_ohms,
	output logic [ntc_pkg::V_W-1:0]             echo_microvolts,
	input  wire logic                           cfg_wr_en,
	input  wire logic [ntc_pkg::IDX_W-1:0]      cfg_wr_index,
	input  wire logic [ntc_pkg::CFG_W-1:0]      cfg_wr_data
);

	// Configuration registers.
	logic [ntc_pkg::V_W-1:0]  vs_q, vc_q;
	logic [ntc_pkg::R_W-1:0]  rf_q, r0_q, rc_q;
	logic [ntc_pkg::T0_W-1:0] t0_q;
	logic [ntc_pkg::B_W-1:0]  b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vs_q <= ntc_pkg::RST_SUPPLY;
			rf_q <= ntc_pkg::RST_FIXED_R;
			r0_q <= ntc_pkg::RST_NOMINAL;
			t0_q <= ntc_pkg::RST_REF_MK;
			b_q  <= ntc_pkg::RST_BETA;
			vc_q <= ntc_pkg::RST_CAL_UV;
			rc_q <= ntc_pkg::RST_CAL_OHMS;
		end else if (cfg_wr_en) begin
			unique case (cfg_wr_index)
				ntc_pkg::REG_SUPPLY:   vs_q <= cfg_wr_data[ntc_pkg::V_W-1:0];
				ntc_pkg::REG_FIXED_R:  rf_q <= cfg_wr_data;
				ntc_pkg::REG_NOMINAL:  r0_q <= cfg_wr_data;
				ntc_pkg::REG_REF_MK:   t0_q <= cfg_wr_data[ntc_pkg::T0_W-1:0];
				ntc_pkg::REG_BETA:     b_q  <= cfg_wr_data[ntc_pkg::B_W-1:0];
				ntc_pkg::REG_CAL_UV:   vc_q <= cfg_wr_data[ntc_pkg::V_W-1:0];
				ntc_pkg::REG_CAL_OHMS: rc_q <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	// The whole pipeline moves when the output register is free or being drained.
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// Stage 1: calibration products, divider products and range checks.
	logic                     vld_s1, calbad_s1, rng_s1, vgt_s1;
	logic [ntc_pkg::V_W-1:0]  v_s1, dv_s1;
	logic [46:0]              cala_s1, calb_s1, rfv_s1, rcvs_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s1      <= sample_microvolts;
			calbad_s1 <= (rf_q == '0) || (rc_q == '0) || (vc_q == '0) || (vc_q >= vs_q);
			cala_s1   <= 47'(rc_q) * 47'(vs_q - vc_q);
			calb_s1   <= 47'(rf_q) * 47'(vc_q);
			rng_s1    <= (sample_microvolts == '0) || (sample_microvolts >= vs_q);
			rfv_s1    <= 47'(rf_q) * 47'(sample_microvolts);
			rcvs_s1   <= 47'(rc_q) * 47'(vs_q);
			vgt_s1    <= sample_microvolts > vc_q;
			dv_s1     <= (sample_microvolts > vc_q) ? sample_microvolts - vc_q
			                                        : vc_q - sample_microvolts;
		end
	end

	// Stage 2: status so far, p = Rf*V*Vc and q = Rc*Vs*|V-Vc|.
	logic                    vld_s2, vgt_s2;
	ntc_pkg::status_t        st_s2;
	logic [ntc_pkg::V_W-1:0] v_s2;
	logic [69:0]             p_s2, q_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (calbad_s1 || !(cala_s1 > calb_s1)) begin
				st_s2 <= ntc_pkg::ST_UNCAL;
			end else if (rng_s1) begin
				st_s2 <= ntc_pkg::ST_RANGE;
			end else begin
				st_s2 <= ntc_pkg::ST_OK;
			end
			v_s2   <= v_s1;
			vgt_s2 <= vgt_s1;
			p_s2   <= 70'(rfv_s1) * 70'(vc_q);
			q_s2   <= 70'(rcvs_s1) * 70'(dv_s1);
		end
	end

	// Stage 3: divider denominator D and the non-positive check.
	logic                    vld_s3;
	ntc_pkg::status_t        st_s3;
	logic [ntc_pkg::V_W-1:0] v_s3;
	logic [69:0]             p_s3;
	logic [70:0]             d_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (st_s2 == ntc_pkg::ST_OK && vgt_s2 && q_s2 >= p_s2) begin
				st_s3 <= ntc_pkg::ST_RES;
			end else begin
				st_s3 <= st_s2;
			end
			d_s3 <= vgt_s2 ? 71'(p_s2) - 71'(q_s2) : 71'(p_s2) + 71'(q_s2);
			p_s3 <= p_s2;
			v_s3 <= v_s2;
		end
	end

	// Stage 4: partial products of N = p*Rc and of D*R0.
	logic                    vld_s4;
	ntc_pkg::status_t        st_s4;
	logic [ntc_pkg::V_W-1:0] v_s4;
	logic [70:0]             d_s4;
	logic [58:0]             nlo_s4, nhi_s4, dhi_s4;
	logic [59:0]             dlo_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nlo_s4 <= 59'(p_s3[34:0]) * 59'(rc_q);
			nhi_s4 <= 59'(p_s3[69:35]) * 59'(rc_q);
			dlo_s4 <= 60'(d_s3[35:0]) * 60'(r0_q);
			dhi_s4 <= 59'(d_s3[70:36]) * 59'(r0_q);
			d_s4   <= d_s3;
			st_s4  <= st_s3;
			v_s4   <= v_s3;
		end
	end

	// Stage 5: assemble N and the log denominator D*R0.
	logic                    vld_s5;
	ntc_pkg::status_t        st_s5;
	logic [ntc_pkg::V_W-1:0] v_s5;
	logic [70:0]             d_s5;
	logic [93:0]             n_s5;
	logic [94:0]             den_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s5   <= (94'(nhi_s4) << 35) + 94'(nlo_s4);
			den_s5 <= (95'(dhi_s4) << 36) + 95'(dlo_s4);
			d_s5   <= d_s4;
			st_s5  <= st_s4;
			v_s5   <= v_s4;
		end
	end

	// Stage 6: leading zero counts and the rounded resistance numerator.
	logic                    vld_s6;
	ntc_pkg::status_t        st_s6;
	logic [ntc_pkg::V_W-1:0] v_s6;
	logic [70:0]             d_s6;
	logic [93:0]             n_s6;
	logic [94:0]             den_s6, numo_s6;
	logic [6:0]              lzn_s6, lzd_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lzn_s6  <= ntc_pkg::lzc96(96'(n_s5));
			lzd_s6  <= ntc_pkg::lzc96(96'(den_s5));
			numo_s6 <= 95'(n_s5) + 95'(d_s5 >> 1);
			n_s6    <= n_s5;
			den_s6  <= den_s5;
			d_s6    <= d_s5;
			st_s6   <= st_s5;
			v_s6    <= v_s5;
		end
	end

	// Division chain: resistance quotient and normalized log mantissa, one bit a stage.
	ntc_pkg::div_t              div_s [ntc_pkg::DIV_N+1];
	logic [ntc_pkg::DIV_N:0]    div_vld_s;
	ntc_pkg::div_t              div_in;

	// The log divide starts with the normalized numerator as its partial remainder.
	always_comb begin
		div_in       = '0;
		div_in.st    = st_s6;
		div_in.v     = v_s6;
		div_in.r_o   = 96'(numo_s6);
		div_in.d     = d_s6;
		div_in.r_l   = 97'(96'(n_s6) << lzn_s6);
		div_in.dd    = 96'(den_s6) << lzd_s6;
		div_in.e     = $signed({1'b0, lzd_s6}) - $signed({1'b0, lzn_s6});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_s[0] <= 1'b0;
		end else if (adv) begin
			div_vld_s[0] <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0] <= div_in;
		end
	end

	for (genvar i = 0; i < ntc_pkg::DIV_N; i++) begin : g_div
		localparam int OB = (i == 0) ? ntc_pkg::OHMS_W :
		                    ((i <= ntc_pkg::OHMS_W) ? ntc_pkg::OHMS_W - i : 0);
		localparam int LB = ntc_pkg::LOGQ_W - 1 - i;
		ntc_pkg::div_t nx;
		logic [95:0]   osub;
		logic [96:0]   rs;

		always_comb begin
			nx   = div_s[i];
			osub = 96'(div_s[i].d) << OB;
			rs   = (i == 0) ? div_s[i].r_l : div_s[i].r_l << 1;
			// Resistance: overflow check first, then quotient bits from the top.
			if (i == 0) begin
				nx.sat_o = div_s[i].r_o >= osub;
			end else if (i <= ntc_pkg::OHMS_W) begin
				if (div_s[i].r_o >= osub) begin
					nx.r_o = div_s[i].r_o - osub;
					nx.q_o[OB % ntc_pkg::OHMS_W] = 1'b1;
				end
			end
			// Log mantissa: quotient of numerator * 2^32 over the denominator.
			nx.r_l = rs;
			if (rs >= 97'(div_s[i].dd)) begin
				nx.r_l = rs - 97'(div_s[i].dd);
				nx.q_l[LB] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				div_vld_s[i+1] <= div_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[i+1] <= nx;
			end
		end
	end

	// Squaring chain: one fraction bit of log2(m) per stage.
	ntc_pkg::sq_t                sq_s [ntc_pkg::LOG_STEPS+1];
	logic [ntc_pkg::LOG_STEPS:0] sq_vld_s;
	ntc_pkg::sq_t                sq_in;
	ntc_pkg::div_t               dlast;

	always_comb begin
		dlast      = div_s[ntc_pkg::DIV_N];
		sq_in.st   = dlast.st;
		sq_in.v    = dlast.v;
		sq_in.ohms = dlast.sat_o ? ntc_pkg::OHMS_MAX : dlast.q_o;
		sq_in.frac = '0;
		if (dlast.q_l[ntc_pkg::LOGQ_W-1]) begin
			sq_in.m = dlast.q_l[ntc_pkg::LOGQ_W-1:1];
			sq_in.e = dlast.e;
		end else begin
			sq_in.m = dlast.q_l[31:0];
			sq_in.e = dlast.e - 8'sd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s[0] <= 1'b0;
		end else if (adv) begin
			sq_vld_s[0] <= div_vld_s[ntc_pkg::DIV_N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s[0] <= sq_in;
		end
	end

	for (genvar k = 0; k < ntc_pkg::LOG_STEPS; k++) begin : g_sq
		ntc_pkg::sq_t nx;
		logic [63:0]  sqr;

		always_comb begin
			nx  = sq_s[k];
			sqr = 64'(sq_s[k].m) * 64'(sq_s[k].m);
			if (sqr[63]) begin
				nx.m = sqr[63:32];
				nx.frac[31-k] = 1'b1;
			end else begin
				nx.m = sqr[62:31];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				sq_vld_s[k+1] <= sq_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s[k+1] <= nx;
			end
		end
	end

	// Kelvin stage 1: ln terms e*ln2 and frac*ln2, and 1000*beta.
	ntc_pkg::sq_t            sqo;
	logic                    vld_sk1, kbad_sk1;
	ntc_pkg::status_t        st_sk1;
	logic [ntc_pkg::V_W-1:0] v_sk1;
	logic [ntc_pkg::R_W-1:0] ohms_sk1;
	logic [63:0]             fl_sk1;
	logic signed [40:0]      el_sk1;
	logic [26:0]             b1000_sk1;

	assign sqo = sq_s[ntc_pkg::LOG_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sk1 <= 1'b0;
		end else if (adv) begin
			vld_sk1 <= sq_vld_s[ntc_pkg::LOG_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fl_sk1    <= 64'(sqo.frac) * 64'(ntc_pkg::LN2_Q32);
			el_sk1    <= 41'(sqo.e) * 41'($signed({1'b0, ntc_pkg::LN2_Q32}));
			b1000_sk1 <= 27'(b_q) * 27'(ntc_pkg::MILLI);
			kbad_sk1  <= (r0_q == '0) || (t0_q == '0) || (b_q == '0);
			st_sk1    <= sqo.st;
			v_sk1     <= sqo.v;
			ohms_sk1  <= sqo.ohms;
		end
	end

	// Kelvin stage 2: ln(R/R0) in Q32.
	logic                    vld_sk2, kbad_sk2;
	ntc_pkg::status_t        st_sk2;
	logic [ntc_pkg::V_W-1:0] v_sk2;
	logic [ntc_pkg::R_W-1:0] ohms_sk2;
	logic signed [41:0]      l_sk2;
	logic [26:0]             b1000_sk2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sk2 <= 1'b0;
		end else if (adv) begin
			vld_sk2 <= vld_sk1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			l_sk2     <= 42'(el_sk1) + $signed({10'd0, fl_sk1[63:32]});
			b1000_sk2 <= b1000_sk1;
			kbad_sk2  <= kbad_sk1;
			st_sk2    <= st_sk1;
			v_sk2     <= v_sk1;
			ohms_sk2  <= ohms_sk1;
		end
	end

	// Kelvin stage 3: T0*ln and the numerator constant 1000*T0*beta.
	logic                    vld_sk3, kbad_sk3;
	ntc_pkg::status_t        st_sk3;
	logic [ntc_pkg::V_W-1:0] v_sk3;
	logic [ntc_pkg::R_W-1:0] ohms_sk3;
	logic signed [62:0]      tl_sk3;
	logic [46:0]             kt_sk3;
	logic [26:0]             b1000_sk3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sk3 <= 1'b0;
		end else if (adv) begin
			vld_sk3 <= vld_sk2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tl_sk3    <= 63'($signed({1'b0, t0_q})) * 63'(l_sk2);
			kt_sk3    <= 47'(t0_q) * 47'(b1000_sk2);
			b1000_sk3 <= b1000_sk2;
			kbad_sk3  <= kbad_sk2;
			st_sk3    <= st_sk2;
			v_sk3     <= v_sk2;
			ohms_sk3  <= ohms_sk2;
		end
	end

	// Kelvin division chain: denominator check, then one quotient bit per stage.
	ntc_pkg::td_t           td_s [ntc_pkg::TD_N+1];
	logic [ntc_pkg::TD_N:0] td_vld_s;
	ntc_pkg::td_t           td_in;
	logic signed [63:0]     kden;

	always_comb begin
		kden       = $signed({5'd0, b1000_sk3, 32'd0}) + 64'(tl_sk3);
		td_in.st   = st_sk3;
		td_in.v    = v_sk3;
		td_in.ohms = ohms_sk3;
		td_in.kbad = kbad_sk3 || kden[63] || (kden == '0);
		td_in.sat  = 1'b0;
		td_in.q    = '0;
		td_in.den  = kden[59:0];
		td_in.r    = 84'({kt_sk3, 32'd0}) + 84'(kden[59:1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			td_vld_s[0] <= 1'b0;
		end else if (adv) begin
			td_vld_s[0] <= vld_sk3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			td_s[0] <= td_in;
		end
	end

	for (genvar j = 0; j < ntc_pkg::TD_N; j++) begin : g_td
		localparam int TB = (j == 0) ? ntc_pkg::TEMP_W : ntc_pkg::TEMP_W - j;
		ntc_pkg::td_t nx;
		logic [83:0]  tsub;

		always_comb begin
			nx   = td_s[j];
			tsub = 84'(td_s[j].den) << TB;
			if (j == 0) begin
				nx.sat = td_s[j].r >= tsub;
			end else if (td_s[j].r >= tsub) begin
				nx.r = td_s[j].r - tsub;
				nx.q[TB % ntc_pkg::TEMP_W] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				td_vld_s[j+1] <= 1'b0;
			end else if (adv) begin
				td_vld_s[j+1] <= td_vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				td_s[j+1] <= nx;
			end
		end
	end

	// Output register: saturate Kelvin, offset to Celsius, apply final status.
	ntc_pkg::td_t             tdo;
	logic [ntc_pkg::TEMP_W-1:0] tk;
	ntc_pkg::status_t         st_fin;
	logic                     out_vld_q;
	logic [2:0]               status_q;
	logic [ntc_pkg::TEMP_W-1:0] temp_q;
	logic [ntc_pkg::R_W-1:0]  ohms_q;
	logic [ntc_pkg::V_W-1:0]  echo_q;

	always_comb begin
		tdo = td_s[ntc_pkg::TD_N];
		if (tdo.sat || tdo.q > ntc_pkg::TK_MAX) begin
			tk = ntc_pkg::TK_MAX;
		end else begin
			tk = tdo.q;
		end
		if (tdo.st == ntc_pkg::ST_OK && tdo.kbad) begin
			st_fin = ntc_pkg::ST_KELVIN;
		end else begin
			st_fin = tdo.st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= td_vld_s[ntc_pkg::TD_N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= st_fin;
			temp_q   <= (st_fin == ntc_pkg::ST_OK) ? tk - ntc_pkg::KOFS_MK : '0;
			ohms_q   <= (st_fin == ntc_pkg::ST_OK || st_fin == ntc_pkg::ST_KELVIN) ?
			            tdo.ohms : '0;
			echo_q   <= tdo.v;
		end
	end

	assign out_valid         = out_vld_q;
	assign status            = status_q;
	assign temp_millicelsius = $signed(temp_q);
	assign thermistor_ohms   = ohms_q;
	assign echo_microvolts   = echo_q;

endmodule

`default_nettype wire

@@ design/ntc_chk.sv @@
// Port-level checker for the NTC thermistor converter, attached by a bind below.
// Depends on ntc_pkg for status codes and on the top level's port list.
`timescale 1ns / 1ps
`default_nettype none

module ntc_chk (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 in_ready,
	input wire logic                                 out_valid,
	input wire logic                                 out_ready,
	input wire logic [2:0]                           status,
	input wire logic signed [ntc_pkg::TEMP_W-1:0]    temp_millicelsius,
	input wire logic [ntc_pkg::R_W-1:0]              thermistor_ohms,
	input wire logic [ntc_pkg::V_W-1:0]              echo_microvolts
);

	// A stalled result stays in place until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(temp_millicelsius) && $stable(thermistor_ohms) && $stable(echo_microvolts))
		else $error("stalled result changed");

	// Input is taken exactly when the output side can move.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");

	// Temperature is reported only for a good result.
	a_temp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ntc_pkg::ST_OK |-> temp_millicelsius == '0)
		else $error("temperature set on a failed result");

	// Resistance is cleared when it could not be worked out.
	a_ohms_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ntc_pkg::ST_UNCAL || status == ntc_pkg::ST_RANGE ||
		status == ntc_pkg::ST_RES) |-> thermistor_ohms == '0)
		else $error("resistance set on a failed result");

	// A good temperature lies within the saturation limits.
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ntc_pkg::ST_OK |->
		temp_millicelsius >= -22'sd273150 && temp_millicelsius <= 22'sd2000000)
		else $error("temperature outside its range");

endmodule

bind ntc_thermistor_to_celsius_unit ntc_chk u_ntc_chk (.*);

`default_nettype wire
